>>> hdl/vpfq_pkg.sv
// Package: types, constants and helpers for the voice prompt frame queue
`default_nettype none
package vpfq_pkg;

    // Ring store depth and pointer width
    localparam int unsigned QUEUE_SLOTS = 32;
    localparam int unsigned PTR_W       = (QUEUE_SLOTS > 1) ? $clog2(QUEUE_SLOTS) : 1;

    // Play command layout: 7E 04 03 file-high file-low EF
    localparam int unsigned POS_W       = 3;
    localparam logic [7:0]  BYTE_START  = 8'h7E;
    localparam logic [7:0]  BYTE_COUNT  = 8'h04;
    localparam logic [7:0]  BYTE_SELECT = 8'h03;
    localparam logic [7:0]  BYTE_TERM   = 8'hEF;

    typedef logic [PTR_W-1:0] ptr_t;
    typedef logic [POS_W-1:0] pos_t;

    localparam pos_t POS_START   = 3'd0;
    localparam pos_t POS_COUNT   = 3'd1;
    localparam pos_t POS_SELECT  = 3'd2;
    localparam pos_t POS_FILE_HI = 3'd3;
    localparam pos_t POS_FILE_LO = 3'd4;
    localparam pos_t POS_LAST    = 3'd5;

    // Request codes
    typedef enum logic [1:0] {
        REQ_PUSH     = 2'd0,
        REQ_CHECK    = 2'd1,
        REQ_TX_READY = 2'd2
    } req_t;

    // Advance a ring pointer, wrapping at the store depth
    function automatic ptr_t next_slot(input ptr_t p);
        if (p == ptr_t'(QUEUE_SLOTS - 1))
            return '0;
        else
            return p + ptr_t'(1);
    endfunction

    // Select the command byte for a frame position
    function automatic logic [7:0] frame_byte(input pos_t pos, input logic [15:0] file);
        logic [7:0] b;
        unique case (pos)
            POS_START:   b = BYTE_START;
            POS_COUNT:   b = BYTE_COUNT;
            POS_SELECT:  b = BYTE_SELECT;
            POS_FILE_HI: b = file[15:8];
            POS_FILE_LO: b = file[7:0];
            default:     b = BYTE_TERM;
        endcase
        return b;
    endfunction

endpackage
`default_nettype wire

>>> hdl/vpfq_cmd_if.sv
// Interface: request channel carrying prompt pushes, checks and tx-ready events
`default_nettype none
interface vpfq_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  req_type;
    logic [15:0] prompt_number;
    logic        module_busy;

    modport source (output valid, output req_type, output prompt_number,
                    output module_busy, input ready);
    modport sink   (input valid, input req_type, input prompt_number,
                    input module_busy, output ready);
endinterface
`default_nettype wire

>>> hdl/vpfq_tx_if.sv
// Interface: result channel carrying command bytes for the serial transmitter
`default_nettype none
interface vpfq_tx_if;
    logic       valid;
    logic       ready;
    logic [7:0] tx_byte;
    logic       frame_end;

    modport source (output valid, output tx_byte, output frame_end, input ready);
    modport sink   (input valid, input tx_byte, input frame_end, output ready);
endinterface
`default_nettype wire

>>> hdl/voice_prompt_frame_queue.sv
// Top level: prompt ring store and six-byte play command framer
//
//   channel  dir  handshake      payload
//   cmd      in   valid/ready    req_type[1:0], prompt_number[15:0], module_busy
//   tx       out  valid/ready    tx_byte[7:0], frame_end
//   cfg      in   cfg_wr_en      cfg_wr_data (quiet_mode)
//
// One request is taken per cycle while cmd.ready is high; its byte, if any, shows on tx the next cycle.
// The state update and byte select sit between the request edge and the tx register.
// cmd.ready is low only while a byte waits in the tx register and tx.ready is low.
// Reset clears pointers, frame state, quiet mode and tx valid; no clearing pass.
`default_nettype none
module voice_prompt_frame_queue (
    input  wire logic clk,
    input  wire logic rst_n,
    vpfq_cmd_if.sink  cmd,
    vpfq_tx_if.source tx,
    input  wire logic cfg_wr_en,
    input  wire logic cfg_wr_data
);
    import vpfq_pkg::*;

    logic [15:0] prompt_store [QUEUE_SLOTS];

    ptr_t        wr_ptr_reg, wr_ptr_next;
    ptr_t        rd_ptr_reg, rd_ptr_next;
    pos_t        pos_reg, pos_next;
    logic        frame_active_reg, frame_active_next;
    logic        quiet_mode_reg;
    logic [15:0] current_file_reg;
    logic        tx_valid_reg, tx_valid_next;
    logic [7:0]  tx_byte_reg, tx_byte_next;
    logic        frame_end_reg, frame_end_next;

    logic accept, do_push, do_start, do_advance, do_finish, emit;
    req_t req;

    // Take a request when the tx register is free or being drained
    assign cmd.ready = !tx_valid_reg || tx.ready;
    assign accept    = cmd.valid && cmd.ready;
    assign req       = req_t'(cmd.req_type);

    // Decode the request
    always_comb
    begin
        do_push    = 1'b0;
        do_start   = 1'b0;
        do_advance = 1'b0;
        do_finish  = 1'b0;
        if (accept)
        begin
            unique case (req)
                REQ_PUSH:
                    do_push = !quiet_mode_reg;
                REQ_CHECK:
                    do_start = (rd_ptr_reg != wr_ptr_reg) && !frame_active_reg
                               && !cmd.module_busy;
                REQ_TX_READY:
                begin
                    do_advance = frame_active_reg && (pos_reg != POS_LAST);
                    do_finish  = frame_active_reg && (pos_reg == POS_LAST);
                end
                default: ;
            endcase
        end
    end

    assign emit = do_start || do_advance;

    // Next pointers, frame state and tx register
    always_comb
    begin
        wr_ptr_next       = do_push  ? next_slot(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next       = do_start ? next_slot(rd_ptr_reg) : rd_ptr_reg;
        frame_active_next = frame_active_reg;
        pos_next          = pos_reg;
        if (do_start)
        begin
            frame_active_next = 1'b1;
            pos_next          = POS_START;
        end
        else if (do_advance)
        begin
            pos_next = pos_reg + pos_t'(1);
        end
        else if (do_finish)
        begin
            frame_active_next = 1'b0;
            pos_next          = POS_START;
        end

        tx_valid_next  = tx_valid_reg && !tx.ready;
        tx_byte_next   = tx_byte_reg;
        frame_end_next = frame_end_reg;
        if (emit)
        begin
            tx_valid_next  = 1'b1;
            tx_byte_next   = frame_byte(pos_next, current_file_reg);
            frame_end_next = (pos_next == POS_LAST);
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg       <= '0;
            rd_ptr_reg       <= '0;
            pos_reg          <= POS_START;
            frame_active_reg <= 1'b0;
            quiet_mode_reg   <= 1'b0;
            tx_valid_reg     <= 1'b0;
        end
        else
        begin
            wr_ptr_reg       <= wr_ptr_next;
            rd_ptr_reg       <= rd_ptr_next;
            pos_reg          <= pos_next;
            frame_active_reg <= frame_active_next;
            tx_valid_reg     <= tx_valid_next;
            if (cfg_wr_en)
                quiet_mode_reg <= cfg_wr_data;
        end
    end

    // Hold tx payload
    always_ff @(posedge clk)
    begin
        tx_byte_reg   <= tx_byte_next;
        frame_end_reg <= frame_end_next;
    end

    // Write pushed prompts; read the oldest entry when a frame starts
    always_ff @(posedge clk)
    begin
        if (do_push)
            prompt_store[wr_ptr_reg] <= cmd.prompt_number + 16'd1;
        if (do_start)
            current_file_reg <= prompt_store[rd_ptr_reg];
    end

    assign tx.valid     = tx_valid_reg;
    assign tx.tx_byte   = tx_byte_reg;
    assign tx.frame_end = frame_end_reg;

    // A frame only starts from a non-empty queue
    a_start_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(frame_active_reg) |-> $past(rd_ptr_reg != wr_ptr_reg))
        else $error("frame started on empty queue");

    // A frame ends only after its terminating byte
    a_end_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(frame_active_reg) |-> $past(pos_reg == POS_LAST))
        else $error("frame ended early");

    // Byte position stays at zero outside a frame
    a_pos_idle: assert property (@(posedge clk) disable iff (!rst_n)
        !frame_active_reg |-> (pos_reg == POS_START))
        else $error("byte position moved outside a frame");

    // A new frame begins with the start byte
    a_first_byte: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(frame_active_reg) |-> (tx_valid_reg && tx_byte_reg == BYTE_START
                                     && !frame_end_reg))
        else $error("frame did not open with start byte");

    // The end mark accompanies only the terminating byte
    a_end_mark: assert property (@(posedge clk) disable iff (!rst_n)
        (tx_valid_reg && frame_end_reg) |-> (tx_byte_reg == BYTE_TERM
                                             && pos_reg == POS_LAST))
        else $error("end mark on wrong byte");

endmodule
`default_nettype wire

>>> test/tb_top.sv
// Testbench for the voice prompt frame queue: random and directed requests against a predictor
module tb_top;
    import vpfq_pkg::*;

    // Request code that the block ignores
    localparam logic [1:0] REQ_UNUSED  = 2'd3;
    localparam int         CYCLE_LIMIT = 300000;
    localparam int         DRAIN_LIMIT = 5000;
    localparam int         SETTLE_CYCLES = 4;
    localparam int         REPORT_MAX  = 10;

    typedef struct {
        logic [7:0] cmd_byte;
        logic       last;
    } tx_word_t;

    // Predicts play command bytes and checks them in order
    class play_frame_board;
        logic [15:0] slots [QUEUE_SLOTS];
        ptr_t        wr_slot  = '0;
        ptr_t        rd_slot  = '0;
        pos_t        byte_idx = POS_START;
        bit          sending  = 1'b0;
        logic [15:0] file_no  = '0;
        bit          quiet    = 1'b0;
        tx_word_t    owed_bytes [$];
        int          mismatches = 0;

        function ptr_t advance(ptr_t p);
            return ptr_t'((int'(p) + 1) % QUEUE_SLOTS);
        endfunction

        function logic [7:0] byte_at(pos_t p);
            case (p)
                POS_START:   return BYTE_START;
                POS_COUNT:   return BYTE_COUNT;
                POS_SELECT:  return BYTE_SELECT;
                POS_FILE_HI: return file_no[15:8];
                POS_FILE_LO: return file_no[7:0];
                default:     return BYTE_TERM;
            endcase
        endfunction

        // Update the queue and frame state for one accepted request
        function void note_request(logic [1:0] req, logic [15:0] prompt, logic busy);
            tx_word_t w;
            case (req)
                REQ_PUSH:
                begin
                    if (!quiet)
                    begin
                        slots[wr_slot] = prompt + 16'd1;
                        wr_slot = advance(wr_slot);
                    end
                end
                REQ_CHECK:
                begin
                    if (rd_slot != wr_slot && !sending && !busy)
                    begin
                        file_no  = slots[rd_slot];
                        rd_slot  = advance(rd_slot);
                        sending  = 1'b1;
                        byte_idx = POS_START;
                        w.cmd_byte = BYTE_START;
                        w.last     = 1'b0;
                        owed_bytes.push_back(w);
                    end
                end
                REQ_TX_READY:
                begin
                    if (sending)
                    begin
                        if (byte_idx >= POS_LAST)
                        begin
                            sending  = 1'b0;
                            byte_idx = POS_START;
                        end
                        else
                        begin
                            byte_idx   = byte_idx + pos_t'(1);
                            w.cmd_byte = byte_at(byte_idx);
                            w.last     = (byte_idx == POS_LAST);
                            owed_bytes.push_back(w);
                        end
                    end
                end
                default: ;
            endcase
        endfunction

        function void flag(string what, tx_word_t want, logic [7:0] b, logic fe);
            mismatches++;
            if (mismatches <= REPORT_MAX)
                $display("%s: expected byte %h last %b, got byte %h last %b",
                         what, want.cmd_byte, want.last, b, fe);
        endfunction

        // Compare one accepted byte with the oldest prediction
        function void check_byte(logic [7:0] b, logic fe);
            tx_word_t w;
            if (owed_bytes.size() == 0)
            begin
                w.cmd_byte = 'x;
                w.last     = 'x;
                flag("byte with none due", w, b, fe);
            end
            else
            begin
                w = owed_bytes.pop_front();
                if (w.cmd_byte !== b || w.last !== fe)
                    flag("byte mismatch", w, b, fe);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_wr_en;
    logic cfg_wr_data;
    bit   calm;
    int   idle_pct;
    int   stall_pct;
    int   counted;
    int   cycle_count;
    play_frame_board sb;

    vpfq_cmd_if cmd_ch ();
    vpfq_tx_if  tx_ch ();

    voice_prompt_frame_queue dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd_ch),
        .tx          (tx_ch),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    // Free-running clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Check results first, then note the request taken at this edge
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (tx_ch.valid && tx_ch.ready)
                sb.check_byte(tx_ch.tx_byte, tx_ch.frame_end);
            if (cmd_ch.valid && cmd_ch.ready)
                sb.note_request(cmd_ch.req_type, cmd_ch.prompt_number, cmd_ch.module_busy);
        end
    end

    // Stall the transmitter side at random
    always @(negedge clk)
    begin
        if (rst_n)
            tx_ch.ready = calm || ($urandom_range(99) >= stall_pct);
    end

    // Stop a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    // Drive one request and hold it until the block takes it
    task automatic send_request(logic [1:0] req, logic [15:0] prompt, logic busy);
        @(negedge clk);
        while (!calm && $urandom_range(99) < idle_pct)
        begin
            cmd_ch.valid = 1'b0;
            @(negedge clk);
        end
        cmd_ch.valid         = 1'b1;
        cmd_ch.req_type      = req;
        cmd_ch.prompt_number = prompt;
        cmd_ch.module_busy   = busy;
        do
            @(posedge clk);
        while (!cmd_ch.ready);
    endtask

    task automatic issue(logic [1:0] req, logic [15:0] prompt, logic busy);
        send_request(req, prompt, busy);
        counted++;
    endtask

    // Drop valid and wait until every predicted byte has arrived or the drain limit runs out
    task automatic settle();
        int waited;
        waited = 0;
        @(negedge clk);
        cmd_ch.valid = 1'b0;
        while (sb.owed_bytes.size() != 0 && waited < DRAIN_LIMIT)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_quiet(logic v);
        settle();
        @(negedge clk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = v;
        sb.quiet    = v;
        @(negedge clk);
        cfg_wr_en   = 1'b0;
    endtask

    function automatic logic [15:0] rand_prompt();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 16'h0000;
        if (r == 1)
            return 16'hFFFF;
        return 16'($urandom_range(0, 65535));
    endfunction

    task automatic noise_request();
        issue(2'($urandom_range(0, 3)), rand_prompt(), 1'($urandom_range(0, 1)));
    endtask

    // Mostly whole frames, some queue wraps, the rest stray requests
    task automatic run_phase(int n, int idle, int stall);
        int target;
        int r;
        int k;
        idle_pct  = idle;
        stall_pct = stall;
        target    = counted + n;
        while (counted < target)
        begin
            calm = ($urandom_range(99) < 20);
            r    = $urandom_range(99);
            if (r < 55)
            begin
                k = $urandom_range(0, 3);
                repeat (k) issue(REQ_PUSH, rand_prompt(), 1'($urandom_range(0, 1)));
                issue(REQ_CHECK, rand_prompt(), 1'b0);
                repeat (6)
                begin
                    if ($urandom_range(99) < 15)
                        noise_request();
                    issue(REQ_TX_READY, rand_prompt(), 1'($urandom_range(0, 1)));
                end
            end
            else if (r < 58)
            begin
                k = QUEUE_SLOTS + $urandom_range(0, 2);
                repeat (k) issue(REQ_PUSH, rand_prompt(), 1'($urandom_range(0, 1)));
            end
            else
                noise_request();
        end
        calm = 1'b0;
    endtask

    initial
    begin
        sb = new();
        rst_n                = 1'b0;
        cmd_ch.valid         = 1'b0;
        cmd_ch.req_type      = REQ_PUSH;
        cmd_ch.prompt_number = '0;
        cmd_ch.module_busy   = 1'b0;
        tx_ch.ready          = 1'b0;
        cfg_wr_en            = 1'b0;
        cfg_wr_data          = 1'b0;
        calm                 = 1'b0;
        idle_pct             = 0;
        stall_pct            = 0;
        counted              = 0;
        cycle_count          = 0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Idle tx-ready, check on an empty queue, unknown request
        issue(REQ_TX_READY, 16'h0000, 1'b0);
        issue(REQ_CHECK, 16'h0000, 1'b0);
        issue(REQ_UNUSED, 16'hFFFF, 1'b1);
        // Prompt wraps to file zero, then a plain one
        issue(REQ_PUSH, 16'hFFFF, 1'b1);
        issue(REQ_PUSH, 16'h0000, 1'b0);
        // Blocked while busy, start, blocked while a frame is in flight
        issue(REQ_CHECK, 16'h0000, 1'b1);
        issue(REQ_CHECK, 16'h0000, 1'b0);
        issue(REQ_CHECK, 16'h0000, 1'b0);
        issue(REQ_PUSH, 16'h7FFF, 1'b0);
        repeat (6) issue(REQ_TX_READY, 16'h0000, 1'b0);
        issue(REQ_CHECK, 16'hFFFF, 1'b0);
        repeat (6) issue(REQ_TX_READY, 16'hFFFF, 1'b1);
        // Quiet push is dropped, the queued prompt still goes out
        set_quiet(1'b1);
        issue(REQ_PUSH, 16'h1234, 1'b0);
        issue(REQ_CHECK, 16'h0000, 1'b0);
        repeat (6) issue(REQ_TX_READY, 16'h0000, 1'b0);
        set_quiet(1'b0);

        run_phase(130, 0, 0);
        set_quiet(1'b1);
        run_phase(100, 61, 0);
        set_quiet(1'b0);
        run_phase(140, 0, 61);
        set_quiet(1'b1);
        run_phase(100, 11, 11);
        set_quiet(1'b0);
        run_phase(150, 11, 11);
        settle();

        if (sb.mismatches == 0 && sb.owed_bytes.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
